[rtl/x25_pkg.sv]
// Shared types, constants and microcode tables for the X25519 scalar multiplier.
// Used by x25_fe_unit and x25519_scalar_multiply; depends on nothing else.
`default_nettype none
package x25_pkg;

    // Field prime 2^255 - 19
    localparam logic [254:0] P = {{250{1'b1}}, 5'b01101};
    localparam int unsigned FE_BITS = 255;
    localparam logic [254:0] A24 = 255'd121665;
    // The two zero bits of the exponent p-2 below bit 255
    localparam logic [7:0] EXP_ZERO_LO = 8'd2;
    localparam logic [7:0] EXP_ZERO_HI = 8'd4;
    localparam logic [7:0] LAST_BIT = 8'd254;
    localparam logic [2:0] INIT_LAST_PC = 3'd5;
    localparam logic [4:0] STEP_LAST_PC = 5'd17;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_MOV, OP_ONE, OP_ZERO, OP_A24, OP_LOAD, OP_READ
    } fe_op_t;

    typedef struct packed {
        fe_op_t     op;
        logic [3:0] dst;
        logic [3:0] src_a;
        logic [3:0] src_b;
    } fe_cmd_t;

    // Register file slots; slots 0..3 are the ladder coordinates
    localparam logic [3:0] R_X2  = 4'd0;
    localparam logic [3:0] R_Z2  = 4'd1;
    localparam logic [3:0] R_X3  = 4'd2;
    localparam logic [3:0] R_Z3  = 4'd3;
    localparam logic [3:0] R_X1  = 4'd4;
    localparam logic [3:0] R_A   = 4'd5;
    localparam logic [3:0] R_AA  = 4'd6;
    localparam logic [3:0] R_B   = 4'd7;
    localparam logic [3:0] R_BB  = 4'd8;
    localparam logic [3:0] R_E   = 4'd9;
    localparam logic [3:0] R_C   = 4'd10;
    localparam logic [3:0] R_D   = 4'd11;
    localparam logic [3:0] R_DA  = 4'd12;
    localparam logic [3:0] R_CB  = 4'd13;
    localparam logic [3:0] R_T   = 4'd14;
    localparam logic [3:0] R_K24 = 4'd15;

    function automatic fe_cmd_t mk(fe_op_t op, logic [3:0] d, logic [3:0] a, logic [3:0] b);
        fe_cmd_t c;
        c.op = op;
        c.dst = d;
        c.src_a = a;
        c.src_b = b;
        return c;
    endfunction

    // Reduce t < 3p into [0, p)
    function automatic logic [254:0] fe_reduce(logic [256:0] t);
        logic [256:0] p1;
        logic [256:0] p2;
        logic [256:0] r;
        p1 = {2'b00, P};
        p2 = {1'b0, P, 1'b0};
        if (t >= p2) begin
            r = t - p2;
        end else if (t >= p1) begin
            r = t - p1;
        end else begin
            r = t;
        end
        return r[254:0];
    endfunction

    function automatic fe_cmd_t init_cmd(logic [2:0] pc);
        fe_cmd_t c;
        unique case (pc)
            3'd0: c = mk(OP_LOAD, R_X1, R_X1, R_X1);
            3'd1: c = mk(OP_ONE, R_X2, R_X1, R_X1);
            3'd2: c = mk(OP_ZERO, R_Z2, R_X1, R_X1);
            3'd3: c = mk(OP_MOV, R_X3, R_X1, R_X1);
            3'd4: c = mk(OP_ONE, R_Z3, R_X1, R_X1);
            default: c = mk(OP_A24, R_K24, R_X1, R_X1);
        endcase
        return c;
    endfunction

    // One ladder step: differential add and double
    function automatic fe_cmd_t ladder_cmd(logic [4:0] pc);
        fe_cmd_t c;
        unique case (pc)
            5'd0:  c = mk(OP_ADD, R_A,  R_X2,  R_Z2);
            5'd1:  c = mk(OP_MUL, R_AA, R_A,   R_A);
            5'd2:  c = mk(OP_SUB, R_B,  R_X2,  R_Z2);
            5'd3:  c = mk(OP_MUL, R_BB, R_B,   R_B);
            5'd4:  c = mk(OP_SUB, R_E,  R_AA,  R_BB);
            5'd5:  c = mk(OP_ADD, R_C,  R_X3,  R_Z3);
            5'd6:  c = mk(OP_SUB, R_D,  R_X3,  R_Z3);
            5'd7:  c = mk(OP_MUL, R_DA, R_D,   R_A);
            5'd8:  c = mk(OP_MUL, R_CB, R_C,   R_B);
            5'd9:  c = mk(OP_ADD, R_T,  R_DA,  R_CB);
            5'd10: c = mk(OP_MUL, R_X3, R_T,   R_T);
            5'd11: c = mk(OP_SUB, R_T,  R_DA,  R_CB);
            5'd12: c = mk(OP_MUL, R_T,  R_T,   R_T);
            5'd13: c = mk(OP_MUL, R_Z3, R_X1,  R_T);
            5'd14: c = mk(OP_MUL, R_X2, R_AA,  R_BB);
            5'd15: c = mk(OP_MUL, R_T,  R_K24, R_E);
            5'd16: c = mk(OP_ADD, R_T,  R_AA,  R_T);
            default: c = mk(OP_MUL, R_Z2, R_E, R_T);
        endcase
        return c;
    endfunction

    // Conditional swap done by renaming: x2<->x3 and z2<->z3 when swap is set
    function automatic logic [3:0] swap_addr(logic [3:0] a, logic swap);
        logic [3:0] r;
        r = a;
        if (a[3:2] == 2'b00) begin
            r[1] = a[1] ^ swap;
        end
        return r;
    endfunction

    function automatic fe_cmd_t swap_cmd(fe_cmd_t c, logic swap);
        fe_cmd_t r;
        r = c;
        r.dst = swap_addr(c.dst, swap);
        r.src_a = swap_addr(c.src_a, swap);
        r.src_b = swap_addr(c.src_b, swap);
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/x25_fe_unit.sv]
// Field arithmetic unit mod 2^255-19: 16-entry register file, add/sub/move,
// bit-serial MSB-first multiplier. Depends on x25_pkg.
`default_nettype none
module x25_fe_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cmd_valid,
    input  wire x25_pkg::fe_cmd_t  cmd,
    input  wire logic [254:0]      ld_data,
    output logic                   done,
    output logic [254:0]           rdata
);

    typedef enum logic [1:0] {F_IDLE, F_OPER, F_MUL} fstate_t;

    fstate_t            state_reg;
    logic               done_reg;
    logic [7:0]         cnt_reg;
    x25_pkg::fe_cmd_t   cmd_reg;
    logic [254:0]       opa_reg;
    logic [254:0]       opb_reg;
    logic [254:0]       acc_reg;
    logic [254:0]       rdata_reg;
    logic [254:0]       mem [16];

    logic [256:0]       sum;
    logic [255:0]       diff;
    logic [255:0]       diff_fix;
    logic [254:0]       alu_res;
    logic [254:0]       mul_next;
    logic               mul_last;
    logic               wr_en;
    logic [254:0]       wr_data;

    always_comb begin
        sum = {2'b00, opa_reg} + {2'b00, opb_reg};
        diff = {1'b0, opa_reg} - {1'b0, opb_reg};
        diff_fix = diff + {1'b0, x25_pkg::P};
        mul_next = x25_pkg::fe_reduce({1'b0, acc_reg, 1'b0}
                   + (opa_reg[254] ? {2'b00, opb_reg} : 257'd0));
        mul_last = (cnt_reg == x25_pkg::LAST_BIT);
        unique case (cmd_reg.op)
            x25_pkg::OP_ADD:  alu_res = x25_pkg::fe_reduce(sum);
            x25_pkg::OP_SUB:  alu_res = diff[255] ? diff_fix[254:0] : diff[254:0];
            x25_pkg::OP_MOV:  alu_res = opa_reg;
            x25_pkg::OP_ONE:  alu_res = 255'd1;
            x25_pkg::OP_ZERO: alu_res = '0;
            x25_pkg::OP_A24:  alu_res = x25_pkg::A24;
            x25_pkg::OP_LOAD: alu_res = x25_pkg::fe_reduce({2'b00, ld_data});
            default:          alu_res = opa_reg;
        endcase
        wr_en = ((state_reg == F_OPER) && (cmd_reg.op != x25_pkg::OP_MUL)
                 && (cmd_reg.op != x25_pkg::OP_READ))
                || ((state_reg == F_MUL) && mul_last);
        wr_data = (state_reg == F_MUL) ? mul_next : alu_res;
    end

    // Register file and datapath registers
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cmd_reg.dst] <= wr_data;
        end
        if ((state_reg == F_IDLE) && cmd_valid) begin
            cmd_reg <= cmd;
            opa_reg <= mem[cmd.src_a];
            opb_reg <= mem[cmd.src_b];
        end else if (state_reg == F_MUL) begin
            opa_reg <= {opa_reg[253:0], 1'b0};
        end
        if (state_reg == F_OPER) begin
            acc_reg <= '0;
            rdata_reg <= opa_reg;
        end else if (state_reg == F_MUL) begin
            acc_reg <= mul_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                F_IDLE: begin
                    if (cmd_valid) begin
                        state_reg <= F_OPER;
                    end
                end
                F_OPER: begin
                    if (cmd_reg.op == x25_pkg::OP_MUL) begin
                        cnt_reg <= '0;
                        state_reg <= F_MUL;
                    end else begin
                        done_reg <= 1'b1;
                        state_reg <= F_IDLE;
                    end
                end
                F_MUL: begin
                    cnt_reg <= cnt_reg + 8'd1;
                    if (mul_last) begin
                        done_reg <= 1'b1;
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/x25519_scalar_multiply.sv]
// X25519 scalar multiplier: word loads up to the one with s_tlast, then ladder, inversion and four result words.
// Each multiply runs bit-serially through F_OPER and F_MUL on the field unit; each add/sub finishes in F_OPER.
// After the last load a job runs 255 ladder steps of 10 multiplies and 8 add/sub, then 509
// multiplies for the inversion and final product; loads are accepted whenever s_tready is high.
// One job at a time; loads are refused until all four result words are taken.
// aresetn (synchronous, active low) clears control state only; stores hold their data.
`default_nettype none
module x25519_scalar_multiply (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [135:0]  s_tdata,   // scalar_word, point_word, word_index, zero pad
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,   // result_word, result_index, zero pad
    output logic               m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_INIT, ST_LADDER, ST_ACC1, ST_INV, ST_FINAL, ST_READ
    } state_t;

    state_t             state_reg;
    logic               issued_reg;
    logic [4:0]         pc_reg;
    logic [7:0]         bit_counter_reg;
    logic [7:0]         inv_k_reg;
    logic               inv_mul_reg;
    logic [254:0]       scal_sh_reg;
    logic [255:0]       out_sh_reg;
    logic [1:0]         out_idx_reg;
    logic               m_tvalid_reg;
    logic [63:0]        scalar_store [4];
    logic [63:0]        point_store [4];

    logic               s_accept;
    logic               op_state;
    logic               fe_cmd_valid;
    x25_pkg::fe_cmd_t   fe_cmd;
    logic               fe_done;
    logic [254:0]       fe_rdata;
    logic [254:0]       u_data;
    logic               exp_bit;

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign u_data = {point_store[3][62:0], point_store[2], point_store[1], point_store[0]};
    assign exp_bit = (inv_k_reg != x25_pkg::EXP_ZERO_LO) && (inv_k_reg != x25_pkg::EXP_ZERO_HI);

    always_comb begin
        op_state = 1'b1;
        unique case (state_reg)
            ST_INIT:   fe_cmd = x25_pkg::init_cmd(pc_reg[2:0]);
            ST_LADDER: fe_cmd = x25_pkg::swap_cmd(x25_pkg::ladder_cmd(pc_reg),
                                                  scal_sh_reg[254]);
            ST_ACC1:   fe_cmd = x25_pkg::mk(x25_pkg::OP_ONE, x25_pkg::R_A,
                                            x25_pkg::R_A, x25_pkg::R_A);
            ST_INV:    fe_cmd = x25_pkg::mk(x25_pkg::OP_MUL, x25_pkg::R_A, x25_pkg::R_A,
                                            inv_mul_reg ? x25_pkg::R_Z2 : x25_pkg::R_A);
            ST_FINAL:  fe_cmd = x25_pkg::mk(x25_pkg::OP_MUL, x25_pkg::R_T,
                                            x25_pkg::R_X2, x25_pkg::R_A);
            ST_READ:   fe_cmd = x25_pkg::mk(x25_pkg::OP_READ, x25_pkg::R_T,
                                            x25_pkg::R_T, x25_pkg::R_T);
            default: begin
                op_state = 1'b0;
                fe_cmd = x25_pkg::mk(x25_pkg::OP_READ, x25_pkg::R_T,
                                     x25_pkg::R_T, x25_pkg::R_T);
            end
        endcase
        fe_cmd_valid = op_state && !issued_reg;
    end

    x25_fe_unit u_fe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fe_cmd_valid),
        .cmd       (fe_cmd),
        .ld_data   (u_data),
        .done      (fe_done),
        .rdata     (fe_rdata)
    );

    // Operand stores
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            scalar_store[s_tdata[129:128]] <= s_tdata[63:0];
            point_store[s_tdata[129:128]] <= s_tdata[127:64];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issued_reg <= 1'b0;
            pc_reg <= '0;
            bit_counter_reg <= '0;
            inv_k_reg <= '0;
            inv_mul_reg <= 1'b0;
            out_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fe_cmd_valid) begin
                issued_reg <= 1'b1;
            end
            if (fe_done) begin
                issued_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && s_tlast) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    // clamp: bit 254 set, bits 2..0 clear
                    scal_sh_reg <= {1'b1, scalar_store[3][61:0], scalar_store[2],
                                    scalar_store[1], scalar_store[0][63:3], 3'b000};
                    pc_reg <= '0;
                    state_reg <= ST_INIT;
                end
                ST_INIT: begin
                    if (fe_done) begin
                        if (pc_reg[2:0] == x25_pkg::INIT_LAST_PC) begin
                            pc_reg <= '0;
                            bit_counter_reg <= x25_pkg::LAST_BIT;
                            state_reg <= ST_LADDER;
                        end else begin
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end
                end
                ST_LADDER: begin
                    if (fe_done) begin
                        if (pc_reg == x25_pkg::STEP_LAST_PC) begin
                            pc_reg <= '0;
                            scal_sh_reg <= {scal_sh_reg[253:0], 1'b0};
                            if (bit_counter_reg == 8'd0) begin
                                state_reg <= ST_ACC1;
                            end else begin
                                bit_counter_reg <= bit_counter_reg - 8'd1;
                            end
                        end else begin
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end
                end
                ST_ACC1: begin
                    if (fe_done) begin
                        inv_k_reg <= x25_pkg::LAST_BIT;
                        inv_mul_reg <= 1'b0;
                        state_reg <= ST_INV;
                    end
                end
                ST_INV: begin
                    if (fe_done) begin
                        if (!inv_mul_reg && exp_bit) begin
                            inv_mul_reg <= 1'b1;
                        end else begin
                            inv_mul_reg <= 1'b0;
                            if (inv_k_reg == 8'd0) begin
                                state_reg <= ST_FINAL;
                            end else begin
                                inv_k_reg <= inv_k_reg - 8'd1;
                            end
                        end
                    end
                end
                ST_FINAL: begin
                    if (fe_done) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (fe_done) begin
                        out_sh_reg <= {1'b0, fe_rdata};
                        out_idx_reg <= '0;
                        m_tvalid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // drain result words
            if (m_tvalid_reg && m_tready) begin
                out_sh_reg <= {64'd0, out_sh_reg[255:64]};
                out_idx_reg <= out_idx_reg + 2'd1;
                if (out_idx_reg == 2'd3) begin
                    m_tvalid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {6'd0, out_idx_reg, out_sh_reg[63:0]};
    assign m_tlast = (out_idx_reg == 2'd3);

`ifndef SYNTHESIS
    a_no_issue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !fe_cmd_valid)
        else $error("field op issued while idle");
    a_done_outstanding: assert property (@(posedge aclk) disable iff (!aresetn)
        fe_done |-> issued_reg)
        else $error("field op finished with none outstanding");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("load accepted while results pending");
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result run continued past last word");
`endif

endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for x25519_scalar_multiply: directed table and random word loads,
// results checked against a modular-arithmetic X25519 predictor. Needs rtl/x25_pkg.sv.
`timescale 1ns / 1ps
module tb;

    localparam int unsigned LIMIT_CYCLES = 40_000_000;
    localparam int unsigned LONG_HOLD = 3000;
    localparam int unsigned RAND_ITEMS = 100;
    localparam int unsigned QUIET_FROM = 80;

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } out_word_t;

    typedef struct {
        logic [63:0] scalar;
        logic [63:0] point;
        logic [1:0]  index;
        logic        last;
        logic        typed;
        logic [255:0] result;
    } load_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic m_tlast;

    out_word_t result_q[$];
    logic [63:0] scalar_words[4];
    logic [63:0] point_words[4];
    int unsigned err_count = 0;
    int unsigned jobs_taken = 0;
    int unsigned cycle_count = 0;
    bit quiet = 1'b0;
    bit hold_done = 1'b0;
    load_row_t dir_rows[$];

    x25519_scalar_multiply i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Field arithmetic mod 2^255-19 on reduced operands
    function automatic logic [254:0] fmul(logic [254:0] a, logic [254:0] b);
        logic [509:0] prod;
        prod = {255'd0, a} * {255'd0, b};
        return 255'(prod % {255'd0, x25_pkg::P});
    endfunction

    function automatic logic [254:0] fadd(logic [254:0] a, logic [254:0] b);
        logic [255:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, x25_pkg::P}) s = s - {1'b0, x25_pkg::P};
        return s[254:0];
    endfunction

    function automatic logic [254:0] fsub(logic [254:0] a, logic [254:0] b);
        logic [255:0] s;
        s = {1'b0, a} + {1'b0, x25_pkg::P} - {1'b0, b};
        if (s >= {1'b0, x25_pkg::P}) s = s - {1'b0, x25_pkg::P};
        return s[254:0];
    endfunction

    function automatic logic [255:0] scalar_mult(logic [255:0] k_in, logic [255:0] u_in);
        logic [255:0] k;
        logic [254:0] x1, x2, z2, x3, z3, aa, bb, e, a, b, c, d, da, cb, tmp, inv;
        logic [254:0] pm2;
        logic swap, kt;
        k = k_in;
        k[2:0] = 3'b000;
        k[255] = 1'b0;
        k[254] = 1'b1;
        x1 = 255'({1'b0, u_in[254:0]} % {1'b0, x25_pkg::P});
        x2 = 255'd1; z2 = '0; x3 = x1; z3 = 255'd1; swap = 1'b0;
        for (int t = 254; t >= 0; t--) begin
            kt = k[t];
            swap ^= kt;
            if (swap) begin
                tmp = x2; x2 = x3; x3 = tmp;
                tmp = z2; z2 = z3; z3 = tmp;
            end
            swap = kt;
            a = fadd(x2, z2); aa = fmul(a, a);
            b = fsub(x2, z2); bb = fmul(b, b);
            e = fsub(aa, bb);
            c = fadd(x3, z3); d = fsub(x3, z3);
            da = fmul(d, a); cb = fmul(c, b);
            tmp = fadd(da, cb); x3 = fmul(tmp, tmp);
            tmp = fsub(da, cb); z3 = fmul(x1, fmul(tmp, tmp));
            x2 = fmul(aa, bb);
            z2 = fmul(e, fadd(aa, fmul(x25_pkg::A24, e)));
        end
        if (swap) begin
            x2 = x3; z2 = z3;
        end
        // Fermat inverse z^(p-2)
        pm2 = x25_pkg::P - 255'd2;
        inv = 255'd1;
        for (int t = 254; t >= 0; t--) begin
            inv = fmul(inv, inv);
            if (pm2[t]) inv = fmul(inv, z2);
        end
        return {1'b0, fmul(x2, inv)};
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(3))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_result(logic [255:0] value);
        out_word_t w;
        for (int i = 0; i < 4; i++) begin
            w.word = value[64*i +: 64];
            w.index = 2'(i);
            w.last = (i == 3);
            result_q.push_back(w);
        end
    endtask

    // Drive one load and return at the edge where it is accepted
    task automatic send_load(logic [63:0] sc, logic [63:0] pt, logic [1:0] idx, logic last,
                             logic typed, logic [255:0] typed_result);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, idx, pt, sc};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scalar_words[idx] = sc;
        point_words[idx] = pt;
        if (last) begin
            if (typed) queue_result(typed_result);
            else queue_result(scalar_mult({scalar_words[3], scalar_words[2], scalar_words[1],
                                           scalar_words[0]},
                                          {point_words[3], point_words[2], point_words[1],
                                           point_words[0]}));
        end
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic add_row(logic [63:0] sc, logic [63:0] pt, logic [1:0] idx, logic last,
                           logic typed = 1'b0, logic [255:0] res = '0);
        load_row_t r;
        r.scalar = sc; r.point = pt; r.index = idx; r.last = last;
        r.typed = typed; r.result = res;
        dir_rows.push_back(r);
    endtask

    // Receiver: random stall bursts, one long hold-off on the second job's results
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!hold_done && jobs_taken == 1 && m_tvalid) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (!quiet && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        out_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.word = m_tdata[63:0];
            got.index = m_tdata[65:64];
            got.last = m_tlast;
            if (result_q.size() == 0) begin
                $error("unexpected result word %h index %0d", got.word, got.index);
                err_count++;
            end else begin
                want = result_q.pop_front();
                if (got.word !== want.word) begin
                    $error("result_word: expected %h, got %h", want.word, got.word);
                    err_count++;
                end
                if (got.index !== want.index) begin
                    $error("result_index: expected %0d, got %0d", want.index, got.index);
                    err_count++;
                end
                if (got.last !== want.last) begin
                    $error("result_last: expected %0d, got %0d", want.last, got.last);
                    err_count++;
                end
                if (got.last) jobs_taken++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        // RFC 7748 vector, loaded out of order
        add_row(64'h185afcc10a4c1462, 64'h3b35b326ec246672, 2'd2, 1'b0);
        add_row(64'h9d7c52f06be346a5, 64'hdb3030586768dbe6, 2'd0, 1'b0);
        add_row(64'hc49a44ba44226a50, 64'h4c1cabd0a603a910, 2'd3, 1'b0);
        add_row(64'hdd5e46824b15163b, 64'h7c5fb124a4c19435, 2'd1, 1'b1, 1'b1,
                {64'h5285a2775507b454, 64'hf7711c4903cfec32,
                 64'h4f088df24dea948e, 64'h90c6e99d3755dac3});
        // Zero u gives zero
        add_row('1, '0, 2'd0, 1'b0);
        add_row('0, '0, 2'd1, 1'b0);
        add_row('1, '0, 2'd2, 1'b0);
        add_row('0, '0, 2'd3, 1'b1, 1'b1, '0);
        // All-ones scalar and non-canonical u, with a repeated position
        add_row(64'h1234, 64'h5678, 2'd3, 1'b0);
        add_row('1, '1, 2'd3, 1'b0);
        add_row('1, '1, 2'd2, 1'b0);
        add_row('1, '1, 2'd1, 1'b0);
        add_row('1, '1, 2'd0, 1'b1);
        // Stores kept: only word 0 rewritten
        add_row(64'h0000000000000007, 64'hffffffffffffffed, 2'd0, 1'b1);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_load(dir_rows[i].scalar, dir_rows[i].point, dir_rows[i].index,
                      dir_rows[i].last, dir_rows[i].typed, dir_rows[i].result);
            // Pause once until the first job has fully drained
            if (i == 3) begin
                s_tvalid <= 1'b0;
                wait (result_q.size() == 0);
                @(posedge aclk);
            end else if (i != 7) begin
                sender_gap();
            end
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n >= QUIET_FROM) quiet = 1'b1;
            send_load(rand_word(), rand_word(), 2'($urandom_range(3)),
                      (n % 33 == 32) || (n == RAND_ITEMS - 1), 1'b0, '0);
            sender_gap();
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        wait (result_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
